### hdl/multi_channel_soft_timer_assert.svh
// assertion macros used by the soft timer controller
`ifndef MULTI_CHANNEL_SOFT_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_ASSERT_SVH

// same-cycle implication
`define MCST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mcst_pkg.sv
// types and constants of the soft timer bank
package mcst_pkg;

	localparam int NUM_TIMERS  = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int FUNC_W  = 3;
	localparam int TIDX_W  = 3;
	localparam int LOAD_W  = 16;
	localparam int MASK_W  = 8;
	localparam int TICK_W  = 32;
	localparam int IN_DW   = 24;
	localparam int OUT_DW  = 48;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 3'd0,
		FN_SET   = 3'd1,
		FN_START = 3'd2,
		FN_STOP  = 3'd3,
		FN_RESET = 3'd4,
		FN_DELAY = 3'd5
	} fn_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             in_ready;
		logic             capture;
		logic             sweep;
		logic [IDX_W-1:0] sweep_idx;
		logic             exec;
		logic             load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_is_tick;
		logic out_free;
	} dp_sts_t;

endpackage

### hdl/mcst_ctrl.sv
// controller: sequences the per-timer sweep and result handoff
module mcst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  mcst_pkg::dp_sts_t  sts,
	output mcst_pkg::ctl_cmd_t cmd
);

	localparam logic [mcst_pkg::IDX_W-1:0] LAST_IDX = mcst_pkg::IDX_W'(mcst_pkg::NUM_TIMERS - 1);

	mcst_pkg::state_t              state_q, state_d;
	logic [mcst_pkg::IDX_W-1:0]    idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcst_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd           = '0;
		cmd.sweep_idx = idx_q;
		unique case (state_q)
			mcst_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.capture = 1'b1;
					idx_d       = '0;
					state_d     = sts.in_is_tick ? mcst_pkg::ST_SWEEP : mcst_pkg::ST_EXEC;
				end
			end
			mcst_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = mcst_pkg::ST_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			mcst_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = mcst_pkg::ST_DONE;
			end
			mcst_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = mcst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcst_pkg::ST_IDLE;
			end
		endcase
	end

`include "multi_channel_soft_timer_assert.svh"

	`MCST_ASSERT_NXT(a_tick_starts_sweep, clk, arst_n, cmd.capture && sts.in_is_tick, state_q == mcst_pkg::ST_SWEEP && idx_q == '0, "tick did not start sweep at timer zero")
	`MCST_ASSERT_NXT(a_sweep_ends, clk, arst_n, state_q == mcst_pkg::ST_SWEEP && idx_q == LAST_IDX, state_q == mcst_pkg::ST_DONE, "sweep overran last timer")
	`MCST_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.load_out, sts.out_free, "result loaded over a pending result")
	`MCST_ASSERT_NXT(a_load_returns_idle, clk, arst_n, cmd.load_out, state_q == mcst_pkg::ST_IDLE && cmd.in_ready, "not ready after result handoff")

endmodule

### hdl/mcst_datapath.sv
// datapath: timer bank, tick and delay counters, output register
module mcst_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcst_pkg::ctl_cmd_t          cmd,
	output mcst_pkg::dp_sts_t           sts,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mcst_pkg::IN_DW-1:0]  s_axis_tdata,
	input  logic [mcst_pkg::FUNC_W-1:0] s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mcst_pkg::OUT_DW-1:0] m_axis_tdata
);

	localparam int N  = mcst_pkg::NUM_TIMERS;
	localparam int CW = mcst_pkg::COUNT_WIDTH;

	// captured request
	mcst_pkg::fn_t                  func_q;
	logic [mcst_pkg::TIDX_W-1:0]    tidx_q;
	logic [mcst_pkg::LOAD_W-1:0]    value_q;
	logic                           one_q;

	// timer bank
	logic [N-1:0]                   en_q;
	logic [N-1:0]                   os_q;
	logic [CW-1:0]                  cnt_q [N];
	logic [CW-1:0]                  rel_q [N];

	logic [mcst_pkg::TICK_W-1:0]    tick_q;
	logic [mcst_pkg::LOAD_W-1:0]    delay_q;
	logic [N-1:0]                   fired_q;

	logic                           out_valid_q;
	logic [mcst_pkg::OUT_DW-1:0]    out_data_q;

	logic [mcst_pkg::IDX_W-1:0]     xsel;
	logic                           xvalid;
	logic [CW-1:0]                  dec;

	assign xsel   = mcst_pkg::IDX_W'(tidx_q);
	assign xvalid = 32'(tidx_q) < N;
	assign dec    = cnt_q[cmd.sweep_idx] - 1'b1;

	assign sts.in_valid   = s_axis_tvalid;
	assign sts.in_is_tick = s_axis_tuser == mcst_pkg::FN_TICK;
	assign sts.out_free   = !out_valid_q || m_axis_tready;

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= mcst_pkg::fn_t'(s_axis_tuser);
			tidx_q  <= s_axis_tdata[2:0];
			value_q <= s_axis_tdata[18:3];
			one_q   <= s_axis_tdata[19];
		end
		if (cmd.load_out) begin
			out_data_q <= {7'd0, delay_q != '0, tick_q, mcst_pkg::MASK_W'(fired_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= '0;
			os_q        <= '0;
			tick_q      <= '0;
			delay_q     <= '0;
			fired_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N; i++) begin
				cnt_q[i] <= '0;
				rel_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				fired_q <= '0;
				if (sts.in_is_tick) begin
					tick_q <= tick_q + 1'b1;
					if (delay_q != '0) begin
						delay_q <= delay_q - 1'b1;
					end
				end
			end
			// one timer per cycle during a tick sweep
			if (cmd.sweep && en_q[cmd.sweep_idx]) begin
				if (dec == '0) begin
					cnt_q[cmd.sweep_idx]   <= rel_q[cmd.sweep_idx];
					fired_q[cmd.sweep_idx] <= 1'b1;
					if (os_q[cmd.sweep_idx]) begin
						en_q[cmd.sweep_idx] <= 1'b0;
					end
				end else begin
					cnt_q[cmd.sweep_idx] <= dec;
				end
			end
			if (cmd.exec) begin
				case (func_q)
					mcst_pkg::FN_DELAY: begin
						delay_q <= value_q;
					end
					mcst_pkg::FN_SET: begin
						if (xvalid) begin
							os_q[xsel]  <= one_q;
							cnt_q[xsel] <= CW'(value_q);
							rel_q[xsel] <= CW'(value_q);
						end
					end
					mcst_pkg::FN_START: begin
						if (xvalid) begin
							en_q[xsel] <= 1'b1;
						end
					end
					mcst_pkg::FN_STOP: begin
						if (xvalid) begin
							en_q[xsel] <= 1'b0;
						end
					end
					mcst_pkg::FN_RESET: begin
						if (xvalid) begin
							en_q[xsel]  <= 1'b0;
							cnt_q[xsel] <= rel_q[xsel];
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/multi_channel_soft_timer.sv
// top level of the multi-channel soft timer bank
// usage:
//   one request enters on the s_axis channel; tuser selects the function
//   (tick, set, start, stop, reset, delay load), tdata carries timer index,
//   load value and the one-shot flag
//   each request yields exactly one response on m_axis: fired mask, the
//   free-running tick count and the delay-busy flag
// throughput:
//   a tick sweeps the bank one timer per cycle, then its response loads into
//   the output register once that is free; other requests pass through a
//   single execute step instead; the controller takes no new request until
//   the previous response is loaded; the timer sweep sets the rate
// reset:
//   arst_n clears all timers (disabled, periodic, count and reload zero),
//   the tick and delay counters and any pending response
// stalls:
//   a response waits in the output register while m_axis_tready is low;
//   the next request may be accepted meanwhile, but its response holds
//   until the pending one is taken
module multi_channel_soft_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // timer_index[2:0], load_value[18:3], one_shot[19]
	input  logic [2:0]  s_axis_tuser,  // func[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // fired_mask[7:0], tick_count[39:8], delay_busy[40]
);

	mcst_pkg::ctl_cmd_t cmd;
	mcst_pkg::dp_sts_t  sts;

	// sequencing of sweep, command execution and response handoff
	mcst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// timer state and response register
	mcst_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
